>>> design/bida_pkg.sv
// Shared types and constants for the next-fit bitmap identifier allocator.
package bida_pkg;

  localparam int unsigned LIMIT_W       = 9;
  localparam int unsigned ID_W          = 9;
  localparam int unsigned IDENT_W       = 8;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned DEF_MAX_IDS   = 256;
  localparam int unsigned DEF_WORD_BITS = 32;
  localparam int unsigned RECIP_SHIFT   = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic eval_done;
  } stat_t;

endpackage

>>> design/bida_ctrl.sv
// Controller state machine sequencing requests through the map datapath.
module bida_ctrl
  import bida_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.eval_done) begin
          state_next = S_RESP;
        end else begin
          state_next = S_READ;
        end
      end
      S_RESP: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    m_tvalid    = 1'b0;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
      end
      S_EVAL: begin
        cmd.commit  = stat.eval_done;
        cmd.advance = !stat.eval_done;
      end
      S_RESP: begin
        m_tvalid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output sides open together");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_READ))
    else $error("accepted transfer did not start a map read");

  a_read_then_eval: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_EVAL))
    else $error("map read not followed by evaluation");

endmodule

>>> design/bida_datapath.sv
// Datapath holding the used-ID map, search hint, limit and result registers.
module bida_datapath
  import bida_pkg::*;
#(
  parameter int unsigned MAX_IDS   = DEF_MAX_IDS,
  parameter int unsigned WORD_BITS = DEF_WORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_value,
  input  logic [OP_W-1:0]    req_op,
  input  logic [IDENT_W-1:0] req_ident,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic               res_status,
  output logic [IDENT_W-1:0] res_granted,
  output logic               res_in_use
);

  localparam int unsigned MAP_WORDS = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned RECIP     = ((1 << RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(WORD_BITS - 1);

  function automatic logic [ID_W-1:0] quot(input logic [ID_W-1:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(RECIP);
    return p[RECIP_SHIFT +: ID_W];
  endfunction

  function automatic logic [BIT_W-1:0] rem(input logic [ID_W-1:0] x);
    logic [31:0] r;
    r = 32'(x) - 32'(quot(x)) * 32'(WORD_BITS);
    return r[BIT_W-1:0];
  endfunction

  function automatic logic [LIMIT_W-1:0] clamp(input logic [LIMIT_W-1:0] v);
    logic [LIMIT_W-1:0] c;
    c = v;
    if (32'(v) > 32'(MAX_IDS)) begin
      c = LIMIT_W'(MAX_IDS);
    end
    if (c == '0) begin
      c = LIMIT_W'(1);
    end
    return c;
  endfunction

  localparam logic [LIMIT_W-1:0] LIM_RST  = clamp(LIMIT_RESET);
  localparam logic [ID_W-1:0]    LAST_RST = ID_W'(LIM_RST - LIMIT_W'(1));

  logic [LIMIT_W-1:0]   limit;
  logic [WIDX_W-1:0]    last_word;
  logic [BIT_W-1:0]     last_off;
  logic [ID_W-1:0]      hint;
  op_t                  op_q;
  logic [IDENT_W-1:0]   ident_q;
  logic [BIT_W-1:0]     id_off;
  logic [WIDX_W-1:0]    cur_word;
  logic [WIDX_W-1:0]    start_word;
  logic [BIT_W-1:0]     start_off;
  logic                 second;
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] word_vld;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_vld;

  logic [LIMIT_W-1:0]   cfg_lim;
  logic [ID_W-1:0]      cfg_last;
  logic [ID_W-1:0]      start_id;
  logic [ID_W-1:0]      req_id;
  logic                 req_in_range;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] lim_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] free;
  logic [WORD_BITS-1:0] low;
  logic [BIT_W-1:0]     bit_idx;
  logic                 hit;
  logic [31:0]          id_sum;
  logic [ID_W-1:0]      found_id;
  logic [ID_W-1:0]      id_inc;
  logic [ID_W-1:0]      hint_new;
  logic                 in_range;
  logic [WIDX_W-1:0]    nxt_word;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;

  assign cfg_lim      = clamp(cfg_value);
  assign cfg_last     = ID_W'(cfg_lim - LIMIT_W'(1));
  assign start_id     = (hint >= limit) ? '0 : hint;
  assign req_id       = ID_W'(req_ident);
  assign req_in_range = req_id < limit;

  always_comb begin
    if (rd_vld) begin
      word = rd_data;
    end else if (cur_word == '0) begin
      word = WORD_BITS'(1);
    end else begin
      word = '0;
    end
  end

  always_comb begin
    lim_mask = '1;
    if (cur_word == last_word) begin
      lim_mask = {WORD_BITS{1'b1}} >> (TOP_BIT - last_off);
    end
    hi_mask = {WORD_BITS{1'b1}} << start_off;
    free    = ~word & lim_mask;
    if (cur_word == start_word) begin
      free = free & (second ? ~hi_mask : hi_mask);
    end
    low     = free & (~free + WORD_BITS'(1));
    hit     = |free;
    bit_idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (low[b]) begin
        bit_idx = bit_idx | BIT_W'(b);
      end
    end
  end

  assign id_sum    = 32'(cur_word) * 32'(WORD_BITS) + 32'(bit_idx);
  assign found_id  = id_sum[ID_W-1:0];
  assign id_inc    = found_id + ID_W'(1);
  assign hint_new  = (id_inc == ID_W'(limit)) ? '0 : id_inc;
  assign in_range  = ID_W'(ident_q) < limit;
  assign nxt_word  = (cur_word == last_word) ? '0 : cur_word + WIDX_W'(1);
  assign stat.eval_done = (op_q != OP_ALLOC) || hit || second;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = word;
    if (cmd.commit) begin
      if (op_q == OP_ALLOC && hit) begin
        wr_en   = 1'b1;
        wr_data = word | low;
      end else if (op_q == OP_RELEASE && in_range) begin
        wr_en   = 1'b1;
        wr_data = word & ~(WORD_BITS'(1) << id_off);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur_word] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cur_word];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LIM_RST;
      last_word <= WIDX_W'(quot(LAST_RST));
      last_off  <= rem(LAST_RST);
      hint      <= ID_W'(1);
      word_vld  <= '0;
      rd_vld    <= 1'b0;
    end else if (cfg_we) begin
      limit     <= cfg_lim;
      last_word <= WIDX_W'(quot(cfg_last));
      last_off  <= rem(cfg_last);
      hint      <= ID_W'(1);
      word_vld  <= '0;
    end else begin
      if (wr_en) begin
        word_vld[cur_word] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld <= word_vld[cur_word];
      end
      if (cmd.commit && op_q == OP_ALLOC && hit) begin
        hint <= hint_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op_t'(req_op);
      ident_q <= req_ident;
      id_off  <= rem(req_id);
      second  <= 1'b0;
      start_word <= WIDX_W'(quot(start_id));
      start_off  <= rem(start_id);
      if (op_t'(req_op) == OP_ALLOC) begin
        cur_word <= WIDX_W'(quot(start_id));
      end else if (req_in_range) begin
        cur_word <= WIDX_W'(quot(req_id));
      end else begin
        cur_word <= '0;
      end
    end else if (cmd.advance) begin
      cur_word <= nxt_word;
      second   <= (nxt_word == start_word);
    end
    if (cmd.commit) begin
      case (op_q)
        OP_ALLOC: begin
          res_status  <= !hit;
          res_granted <= hit ? found_id[IDENT_W-1:0] : '0;
          res_in_use  <= 1'b0;
        end
        OP_QUERY: begin
          res_status  <= 1'b0;
          res_granted <= '0;
          res_in_use  <= in_range && word[id_off];
        end
        default: begin
          res_status  <= 1'b0;
          res_granted <= '0;
          res_in_use  <= 1'b0;
        end
      endcase
    end
  end

  a_hit_in_limit: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && op_q == OP_ALLOC && hit) |-> (found_id < limit))
    else $error("granted ID lies at or above the limit");

  a_hint_in_limit: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && op_q == OP_ALLOC && hit) |=> (hint < limit))
    else $error("search hint left at or above the limit");

  a_write_on_commit: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (cmd.commit && !cmd.rd_en && !cfg_we))
    else $error("map written outside a commit");

endmodule

>>> design/bitmap_id_allocator_next_fit.sv
// Top level of the next-fit bitmap identifier allocator.
// Requests arrive on the s_ group: s_tuser carries the operation (allocate,
// release or query) and s_tdata the identifier for release and query.
// Every request gives exactly one result transfer on the m_ group: m_tuser is
// the pool-full status, m_tdata the granted identifier and the query flag.
// The cfg_ channel writes the identifier limit; a write clears the map,
// reserves identifier 0 and sets the search hint to 1. cfg_ready is always high.
// One request is in flight at a time. Release, query and an allocation that
// finds a free identifier in the first map word visited go through one map
// read and one evaluation. An allocation scans one map word at a time
// (registered memory read, then evaluation) and visits at most the number
// of words covering the limit plus one.
// A stalled receiver holds the result in place and the block takes no new
// request until the result transfer completes. Reset restores the limit to
// its default, marks only identifier 0 as used and sets the hint to 1 at once.
module bitmap_id_allocator_next_fit
  import bida_pkg::*;
#(
  parameter int unsigned MAX_IDS   = DEF_MAX_IDS,
  parameter int unsigned WORD_BITS = DEF_WORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,  // [7:0] ident
  input  logic [OP_W-1:0]    s_tuser,  // [1:0] operation
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,  // [7:0] granted_id, [8] in_use, [15:9] zero
  output logic [0:0]         m_tuser   // [0] status
);

  cmd_t               cmd;
  stat_t              stat;
  logic               res_status;
  logic [IDENT_W-1:0] res_granted;
  logic               res_in_use;

  assign cfg_ready = 1'b1;

  bida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bida_datapath #(
    .MAX_IDS   (MAX_IDS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_value   (cfg_data),
    .req_op      (s_tuser),
    .req_ident   (s_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .res_status  (res_status),
    .res_granted (res_granted),
    .res_in_use  (res_in_use)
  );

  assign m_tdata = {7'b0, res_in_use, res_granted};
  assign m_tuser = res_status;

endmodule

>>> verif/tb_bitmap_id_allocator_next_fit.sv
// Self-checking testbench for the next-fit bitmap identifier allocator.
module tb_bitmap_id_allocator_next_fit;
  import bida_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF = 5;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic               status;
    logic [IDENT_W-1:0] granted_id;
    logic               in_use;
  } alloc_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;  // [7:0] ident
  logic [OP_W-1:0]    s_tuser = '0;  // [1:0] operation
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [15:0]        m_tdata;       // [7:0] granted_id, [8] in_use, [15:9] zero
  logic [0:0]         m_tuser;       // [0] status

  logic [DEF_MAX_IDS-1:0] pool_map;
  int unsigned            pool_hint;
  int unsigned            pool_limit;
  alloc_result_t          predicted_responses[$];
  int unsigned            mismatch_count = 0;
  int unsigned            stall_left = 0;
  bit                     no_gaps = 1'b0;

  bitmap_id_allocator_next_fit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int unsigned clamp_limit(logic [LIMIT_W-1:0] code);
    if (code > DEF_MAX_IDS) begin
      return DEF_MAX_IDS;
    end
    if (code == 0) begin
      return 1;
    end
    return 32'(code);
  endfunction

  function automatic void pool_configure(logic [LIMIT_W-1:0] code);
    pool_limit = clamp_limit(code);
    pool_map = '0;
    pool_map[0] = 1'b1;
    pool_hint = 1;
  endfunction

  function automatic alloc_result_t next_fit_outcome(logic [OP_W-1:0] op,
                                                     logic [IDENT_W-1:0] ident);
    alloc_result_t res;
    int unsigned slot;
    res = '0;
    case (op)
      OP_ALLOC: begin
        res.status = 1'b1;
        for (int unsigned i = 0; i < pool_limit; i++) begin
          slot = (pool_hint + i) % pool_limit;
          if (!pool_map[slot]) begin
            pool_map[slot] = 1'b1;
            pool_hint = (slot + 1) % pool_limit;
            res.status = 1'b0;
            res.granted_id = slot[IDENT_W-1:0];
            break;
          end
        end
      end
      OP_RELEASE: begin
        if (ident < pool_limit) begin
          pool_map[ident] = 1'b0;
        end
      end
      OP_QUERY: begin
        res.in_use = (ident < pool_limit) && pool_map[ident];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Picks an identifier that is currently marked used, if there is one, so that releases hit live entries.
  function automatic logic [IDENT_W-1:0] some_used_ident();
    int unsigned first;
    int unsigned k;
    first = $urandom_range(0, pool_limit - 1);
    for (k = 0; k < pool_limit; k++) begin
      if (pool_map[(first + k) % pool_limit]) begin
        return IDENT_W'((first + k) % pool_limit);
      end
    end
    return IDENT_W'(first);
  endfunction

  function automatic int unsigned idle_cycles();
    int unsigned r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      pool_configure(cfg_data);
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predicted_responses.push_back(next_fit_outcome(s_tuser, s_tdata));
    end
  end

  always @(posedge clk) begin : check_responses
    alloc_result_t got;
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser[0];
      got.granted_id = m_tdata[7:0];
      got.in_use = m_tdata[8];
      if (predicted_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected result transfer: status %0d granted_id %0d in_use %0d",
                   got.status, got.granted_id, got.in_use);
        end
      end else begin
        want = predicted_responses.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t: expected status %0d granted_id %0d in_use %0d, ",
                     $realtime, want.status, want.granted_id, want.in_use,
                     "got status %0d granted_id %0d in_use %0d",
                     got.status, got.granted_id, got.in_use);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      stall_left <= idle_cycles();
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Entered and left at a falling edge; the valid stays high for a back-to-back transfer.
  task automatic send_req(input logic [OP_W-1:0] op, input logic [IDENT_W-1:0] ident);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= ident;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (predicted_responses.size() != 0);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] code);
    cfg_valid <= 1'b1;
    cfg_data <= code;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_req(OP_QUERY, 8'd0);
    send_req(OP_QUERY, 8'd255);
    send_req(OP_ALLOC, 8'd255);
    send_req(OP_ALLOC, 8'd0);
    send_req(OP_QUERY, 8'd1);
    send_req(OP_RELEASE, 8'd1);
    send_req(OP_QUERY, 8'd1);
    send_req(OP_UNUSED, 8'd255);
    send_req(OP_RELEASE, 8'd255);
    send_req(OP_QUERY, 8'd255);
  endtask

  task automatic test_tiny_pools();
    wait_idle();
    write_limit(9'd2);
    send_req(OP_ALLOC, 8'd0);
    send_req(OP_ALLOC, 8'd0);
    send_req(OP_RELEASE, 8'd0);
    send_req(OP_ALLOC, 8'd0);
    send_req(OP_QUERY, 8'd5);
    send_req(OP_RELEASE, 8'd5);
    send_req(OP_QUERY, 8'd1);
    wait_idle();
    write_limit(9'd0);
    send_req(OP_ALLOC, 8'd0);
    send_req(OP_RELEASE, 8'd0);
    send_req(OP_ALLOC, 8'd0);
    send_req(OP_ALLOC, 8'd0);
  endtask

  task automatic test_limit_saturation();
    wait_idle();
    write_limit(9'd511);
    send_req(OP_QUERY, 8'd255);
    send_req(OP_ALLOC, 8'd0);
    send_req(OP_RELEASE, 8'd255);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned span;
    int unsigned r;
    logic [LIMIT_W-1:0] code;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: code = 9'd2;
        1: code = LIMIT_W'($urandom_range(3, 8));
        2, 3, 4, 5: code = LIMIT_W'($urandom_range(4, 48));
        6: code = LIMIT_W'($urandom_range(49, 160));
        7: code = 9'd256;
        8: code = LIMIT_W'($urandom_range(257, 511));
        default: code = LIMIT_W'($urandom_range(0, 1));
      endcase
      wait_idle();
      write_limit(code);
      no_gaps = ($urandom_range(0, 3) == 0);
      // Small pools are filled to the brim first so that full pools and wrapping are common.
      if (pool_limit <= 48) begin
        repeat (pool_limit + 1) begin
          send_req(OP_ALLOC, IDENT_W'($urandom_range(0, 255)));
          sent++;
        end
      end
      span = $urandom_range(20, 60);
      repeat (span) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          send_req(OP_ALLOC, IDENT_W'($urandom_range(0, 255)));
          sent++;
        end else if (r < 65) begin
          send_req(OP_RELEASE, some_used_ident());
          sent++;
        end else if (r < 80) begin
          send_req(OP_QUERY, IDENT_W'($urandom_range(0, pool_limit - 1)));
          sent++;
        end else if (r < 83) begin
          wait_idle();
        end else begin
          send_req(OP_W'($urandom_range(0, 3)), IDENT_W'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    pool_configure(LIMIT_RESET);
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_tiny_pools();
    test_limit_saturation();
    test_random_traffic();
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
